// ===== rtl/mcrc_pkg.sv =====
`default_nettype none

package mcrc_pkg;

  // crc-16 of the modbus kind
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // entries in the queue between the front and back parts
  localparam int unsigned QueueDepth = 2;

  // one classified request as it travels through the queue
  typedef struct packed {
    logic [7:0]  data;
    logic        frame_end;
    logic [15:0] crc;
  } mcrc_entry_t;

  // fold one byte into the crc, least significant bit first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mcrc_front.sv =====
`default_nettype none

module mcrc_front
  import mcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output mcrc_entry_t      push_entry_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;

  // accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // running crc, back to start value after the last byte of a frame
  assign crc_next = crc_fold(crc_q, data_byte_i);

  always_comb begin
    crc_d = crc_q;
    if (push_o) begin
      crc_d = frame_end_i ? CrcInit : crc_next;
    end
  end

  // classified request: byte, end mark and crc up to and including it
  assign push_entry_o.data      = data_byte_i;
  assign push_entry_o.frame_end = frame_end_i;
  assign push_entry_o.crc       = crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcrc_queue.sv =====
`default_nettype none

module mcrc_queue
  import mcrc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire mcrc_entry_t  push_entry_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic              full_o,
  output mcrc_entry_t       head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  mcrc_entry_t         entry_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == CntW'(QueueDepth);
  assign head_o  = entry_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcrc_back.sv =====
`default_nettype none

module mcrc_back
  import mcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire mcrc_entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  typedef enum logic [1:0] {
    PhData,
    PhCrcLo,
    PhCrcHi
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        load;

  // output register takes a new byte when empty or being drained
  assign load = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      case (phase_q)
        PhData: begin
          out_byte_d = head_i.data;
          out_last_d = 1'b0;
          if (head_i.frame_end) begin
            phase_d = PhCrcLo;
          end else begin
            pop_o = 1'b1;
          end
        end
        PhCrcLo: begin
          out_byte_d = head_i.crc[7:0];
          out_last_d = 1'b0;
          phase_d    = PhCrcHi;
        end
        PhCrcHi: begin
          out_byte_d = head_i.crc[15:8];
          out_last_d = 1'b1;
          phase_d    = PhData;
          pop_o      = 1'b1;
        end
        default: begin
          phase_d = PhData;
        end
      endcase
    end
  end

  // phase and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhData;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/modbus_crc16_frame_appender_core.sv =====
// channel | signals                               | direction
// input   | in_valid_i, in_ready_o, data_byte_i,  | request in
//         | frame_end_i                           |
// output  | out_valid_o, out_ready_i, out_byte_o, | request out
//         | out_last_o                            |
//
// one input byte per cycle while the queue has room; a byte that ends a frame gives three output bytes
// (data, crc low, crc high), sent one by one through the single output register of the back part.
// from input accept to output valid a byte passes the queue write, then the output register.
// rst_ni clears the crc to 0xFFFF, empties the two-entry queue and the output register.
// the input side stalls only when the queue is full; the output holds while stalled.
`default_nettype none

module modbus_crc16_frame_appender_core
  import mcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  logic        push;
  logic        pop;
  logic        q_valid;
  logic        q_full;
  mcrc_entry_t push_entry;
  mcrc_entry_t head;

  // front: accept bytes and run the crc
  mcrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // queue between front and back
  mcrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .full_o       (q_full),
    .head_o       (head)
  );

  // back: emit data bytes and the crc tail
  mcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mcrc_checker.sv =====
`default_nettype none

module mcrc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] data_byte_i,
  input wire logic       frame_end_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_last_o
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] open_frames_q;
  logic       prev_last_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // frames whose end byte went in but whose crc high byte has not come out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_frames_q <= '0;
      prev_last_q   <= 1'b1;
    end else begin
      open_frames_q <= open_frames_q + 3'(in_acc && frame_end_i)
                       - 3'(out_acc && out_last_o);
      if (out_acc) begin
        prev_last_q <= out_last_o;
      end
    end
  end

  // output register is empty while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // stalled output holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output changed");

  // a frame end only comes out for a frame that went in
  a_last_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_o |-> open_frames_q != 3'd0)
    else $error("frame end without a frame");

  // a crc tail never directly follows another frame end
  a_no_adjacent_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_o |-> !prev_last_q)
    else $error("two frame ends in a row");

  logic unused_ok;
  assign unused_ok = ^data_byte_i;

endmodule

bind modbus_crc16_frame_appender_core mcrc_checker u_mcrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .data_byte_i (data_byte_i),
  .frame_end_i (frame_end_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire

// ===== tb/sv/tb_modbus_crc16_frame_appender_core.sv =====
`timescale 1ns / 100ps

// one expected output byte
typedef struct packed {
  logic [7:0] data;
  logic       last;
} frame_byte_t;

// tracks the running crc and the bytes the block still owes
class frame_crc_scoreboard;
  localparam logic [15:0] SeedValue = 16'hFFFF;
  localparam logic [15:0] ReflPoly  = 16'hA001;

  logic [15:0]  crc_acc;
  frame_byte_t  owed_q[$];
  int unsigned  mismatches;
  int unsigned  bytes_checked;
  int unsigned  frames_closed;

  function new();
    crc_acc       = SeedValue;
    mismatches    = 0;
    bytes_checked = 0;
    frames_closed = 0;
  endfunction

  // bitwise update: feedback bit decides whether the polynomial is folded in
  function logic [15:0] fold_crc_byte(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[k];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ ReflPoly;
      end
    end
    return crc;
  endfunction

  // accepted input request: pass-through byte, plus crc tail on frame end
  function void note_request(logic [7:0] data, logic frame_end);
    crc_acc = fold_crc_byte(crc_acc, data);
    owed_q.push_back('{data: data, last: 1'b0});
    if (frame_end) begin
      owed_q.push_back('{data: crc_acc[7:0], last: 1'b0});
      owed_q.push_back('{data: crc_acc[15:8], last: 1'b1});
      crc_acc = SeedValue;
      frames_closed++;
    end
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  function void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  // accepted output request against the oldest owed byte
  function void check_response(logic [7:0] data, logic last);
    frame_byte_t exp_b;
    bytes_checked++;
    if (owed_q.size() == 0) begin
      log_mismatch($sformatf("unexpected byte %02h last %b", data, last));
      return;
    end
    exp_b = owed_q.pop_front();
    if (data !== exp_b.data) begin
      log_mismatch($sformatf("out_byte expected %02h got %02h", exp_b.data, data));
    end
    if (last !== exp_b.last) begin
      log_mismatch($sformatf("out_last expected %b got %b (byte %02h)",
                             exp_b.last, last, exp_b.data));
    end
  endfunction
endclass

module tb_modbus_crc16_frame_appender_core;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // random gaps on both sides when set, back-to-back otherwise
  logic       gaps_on;
  int unsigned requests_sent;

  frame_crc_scoreboard crc_sb;

  modbus_crc16_frame_appender_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // push one byte through the input handshake
  task automatic send_byte(input logic [7:0] data, input logic frame_end);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = data;
    frame_end_i = frame_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    crc_sb.note_request(data, frame_end);
    requests_sent++;
  endtask

  // frame of random bytes
  task automatic send_random_frame(input int unsigned len);
    for (int unsigned n = 0; n < len; n++) begin
      send_byte(8'($urandom_range(0, 255)), n == len - 1);
    end
  endtask

  // hold the sender until every owed byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (crc_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // output side: random stalls, check every accepted byte
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      crc_sb.check_response(out_byte_o, out_last_o);
    end
  end

  // watchdog
  initial begin
    #2ms;
    $display("modbus_crc16_frame_appender_core regression: fail");
    $finish;
  end

  // main sequence
  initial begin
    logic [7:0] classic_req[6];
    int unsigned len;
    crc_sb        = new();
    requests_sent = 0;
    gaps_on       = 1'b1;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    frame_end_i   = 1'b0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one-byte frames at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // read-holding-registers request, a well-known crc case
    classic_req = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
    foreach (classic_req[i]) begin
      send_byte(classic_req[i], i == 5);
    end
    // alternating, single-bit and all-ones bit patterns, back to back
    gaps_on = 1'b0;
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    gaps_on = 1'b1;
    wait_drained();

    // random frames, mostly short, now and then a long one
    while (requests_sent < 140) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(20, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      send_random_frame(len);
      if (requests_sent > 90 && requests_sent < 110) begin
        wait_drained();
      end
    end

    // drain and let any stray bytes show up
    @(negedge clk_i);
    in_valid_i = 1'b0;
    gaps_on    = 1'b1;
    while (crc_sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d frames, checked %0d output bytes, %0d mismatches",
             requests_sent, crc_sb.frames_closed, crc_sb.bytes_checked, crc_sb.mismatches);
    if (crc_sb.mismatches == 0 && crc_sb.pending() == 0) begin
      $display("modbus_crc16_frame_appender_core regression: pass");
    end else begin
      $display("modbus_crc16_frame_appender_core regression: fail");
    end
    $finish;
  end

endmodule
